// ----- src/rtc_fields_to_unix_seconds_defines.svh -----
// ----------------------------------------------------------------------------
// RTC to Unix seconds: assertion macros
// Shared property forms for the checker of the RTC conversion block.
// ----------------------------------------------------------------------------
`ifndef RTC_FIELDS_TO_UNIX_SECONDS_DEFINES_SVH
`define RTC_FIELDS_TO_UNIX_SECONDS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTCU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rtcu_pkg.sv -----
// ----------------------------------------------------------------------------
// RTC to Unix seconds: package
// Payload types, stage types, constants and the month offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcu_pkg;

  localparam int unsigned SecsPerMinute   = 60;
  localparam int unsigned SecsPerHour     = 3600;
  localparam int unsigned SecsPerDay      = 86400;
  localparam int unsigned SecsPerYear     = 31536000;
  localparam int unsigned EpochYear       = 1970;
  localparam int unsigned BaseYear        = 2000;
  localparam int unsigned YearOffset      = BaseYear - EpochYear;

  localparam logic [7:0] HourPmMask   = 8'h80;
  localparam logic [7:0] HourTensMask = 8'h70;
  localparam logic [7:0] MonthFirst   = 8'd1;
  localparam logic [7:0] MonthMarch   = 8'd3;
  localparam logic [7:0] MonthLast    = 8'd12;
  localparam logic [7:0] HourNoon     = 8'd12;

  localparam int unsigned RelW  = 9;   // years since epoch, up to 285
  localparam int unsigned DaysW = 10;  // day count inside the span, up to 660

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BINARY_MODE  = 1'b0,
    REG_HOUR_24_MODE = 1'b1
  } rtcu_reg_t;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
  } rtcu_in_t;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic        date_invalid;
  } rtcu_out_t;

  typedef struct packed {
    logic binary_mode;
    logic hour_24_mode;
  } rtcu_cfg_t;

  // Decoded fields passed from the decode stage to the summing stage.
  typedef struct packed {
    logic             invalid;
    logic [RelW-1:0]  rel_years;
    logic [DaysW-1:0] extra_days;
    logic [7:0]       hour;
    logic [7:0]       minute;
    logic [7:0]       second;
  } rtcu_dec_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // BCD byte to binary; nibbles above nine pass through the same formula.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return 8'((tens << 3) + (tens << 1) + {4'd0, b[3:0]});
  endfunction

endpackage

`default_nettype wire

// ----- src/rtcu_decode.sv -----
// ----------------------------------------------------------------------------
// RTC to Unix seconds: field decode
// BCD decode, hour mode handling, month check and day count within the span.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcu_decode
  import rtcu_pkg::*;
(
  input  rtcu_in_t  raw,
  input  rtcu_cfg_t cfg,
  output rtcu_dec_t dec
);

  logic [7:0]       second, minute, day, month, year;
  logic [7:0]       hour_base, hour_12, hour;
  logic [2:0]       hour_tens;
  logic             pm;
  logic             month_ok;
  logic             leap_add;
  logic [RelW-1:0]  rel_years;
  logic [RelW-1:0]  leap_days;
  logic [3:0]       month_idx;

  assign pm        = (raw.raw_hour & HourPmMask) != 8'd0;
  assign hour_tens = raw.raw_hour[6:4];

  always_comb begin
    if (cfg.binary_mode) begin
      second    = raw.raw_second;
      minute    = raw.raw_minute;
      day       = raw.raw_day;
      month     = raw.raw_month;
      year      = raw.raw_year;
      hour_base = raw.raw_hour & ~HourPmMask;
    end else begin
      second    = bcd_to_bin(raw.raw_second);
      minute    = bcd_to_bin(raw.raw_minute);
      day       = bcd_to_bin(raw.raw_day);
      month     = bcd_to_bin(raw.raw_month);
      year      = bcd_to_bin(raw.raw_year);
      hour_base = 8'({5'd0, hour_tens} * 8'd10) + {4'd0, raw.raw_hour[3:0]};
    end
  end

  // Twelve o'clock counts as zero, and the PM half adds twelve hours.
  always_comb begin
    hour_12 = (hour_base == HourNoon) ? 8'd0 : hour_base;
    if (pm) begin
      hour_12 = hour_12 + HourNoon;
    end
  end

  // In binary 24-hour mode the whole byte, bit 7 included, is the hour.
  always_comb begin
    if (!cfg.hour_24_mode) begin
      hour = hour_12;
    end else if (cfg.binary_mode) begin
      hour = raw.raw_hour;
    end else begin
      hour = hour_base;
    end
  end

  assign month_ok  = (month >= MonthFirst) && (month <= MonthLast);
  assign month_idx = 4'(month - MonthFirst);
  assign rel_years = RelW'(YearOffset) + {1'b0, year};
  assign leap_days = (rel_years + RelW'(1)) >> 2;
  // Base year is a multiple of four, so the two-digit year decides.
  assign leap_add  = (year[1:0] == 2'd0) && (month >= MonthMarch);

  // Leap days before the year are at least seven, so minus one never wraps.
  always_comb begin
    dec.invalid    = !month_ok;
    dec.rel_years  = rel_years;
    dec.extra_days = DaysW'(days_before_month(month_idx)) + DaysW'(day)
                   + DaysW'(leap_add) + DaysW'(leap_days) - DaysW'(1);
    dec.hour       = hour;
    dec.minute     = minute;
    dec.second     = second;
  end

endmodule

`default_nettype wire

// ----- src/rtcu_sum.sv -----
// ----------------------------------------------------------------------------
// RTC to Unix seconds: seconds sum
// Scales years, days, hours and minutes by constants and adds them and the seconds, mod 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcu_sum
  import rtcu_pkg::*;
(
  input  rtcu_dec_t dec,
  output rtcu_out_t res
);

  logic [31:0] year_secs;
  logic [31:0] day_secs;
  logic [19:0] hour_secs;
  logic [13:0] minute_secs;
  logic [31:0] total;

  assign year_secs   = 32'({23'd0, dec.rel_years} * 32'(SecsPerYear));
  assign day_secs    = 32'({22'd0, dec.extra_days} * 32'(SecsPerDay));
  assign hour_secs   = 20'({12'd0, dec.hour} * 20'(SecsPerHour));
  assign minute_secs = 14'({6'd0, dec.minute} * 14'(SecsPerMinute));

  assign total = year_secs + day_secs + {12'd0, hour_secs} + {18'd0, minute_secs}
               + {24'd0, dec.second};

  always_comb begin
    if (dec.invalid) begin
      res.unix_seconds = 32'd0;
      res.date_invalid = 1'b1;
    end else begin
      res.unix_seconds = total;
      res.date_invalid = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- src/rtc_fields_to_unix_seconds.sv -----
// ----------------------------------------------------------------------------
// RTC fields to Unix seconds
// Converts raw clock-chip bytes (BCD or binary, 12- or 24-hour) to seconds
// since the epoch for years 2000 onward.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid / in_stall  in_data  (rtcu_in_t)
//   out       output     out_valid/out_stall  out_data (rtcu_out_t)
//   config    input      wr_en                wr_index, wr_data
//
// Three register stages: raw input, decoded fields, result. One item is
// accepted every cycle while in_stall is low. The decode stage and the
// summing stage each hold one constant-multiply level. Reset clears the
// stage valid bits and loads the register defaults. A stall on the output
// holds the result; upstream stages keep filling until all three are full,
// then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_fields_to_unix_seconds
  import rtcu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire rtcu_in_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      rtcu_out_t out_data,
  input  wire logic      wr_en,
  input  wire logic      wr_index,
  input  wire logic      wr_data
);

  rtcu_cfg_t cfg;
  logic      raw_valid;
  rtcu_in_t  raw;
  logic      dec_valid;
  rtcu_dec_t dec;
  rtcu_dec_t dec_next;
  rtcu_out_t res_next;
  logic      out_ready, dec_ready, raw_ready;

  assign out_ready = !out_valid || !out_stall;
  assign dec_ready = !dec_valid || out_ready;
  assign raw_ready = !raw_valid || dec_ready;
  assign in_stall  = !raw_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.binary_mode  <= 1'b0;
      cfg.hour_24_mode <= 1'b1;
    end else if (wr_en) begin
      unique case (rtcu_reg_t'(wr_index))
        REG_BINARY_MODE:  cfg.binary_mode  <= wr_data;
        REG_HOUR_24_MODE: cfg.hour_24_mode <= wr_data;
        default: ;
      endcase
    end
  end

  rtcu_decode u_decode (
    .raw (raw),
    .cfg (cfg),
    .dec (dec_next)
  );

  rtcu_sum u_sum (
    .dec (dec),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
      dec_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (raw_ready) begin
        raw_valid <= in_valid;
      end
      if (dec_ready) begin
        dec_valid <= raw_valid;
      end
      if (out_ready) begin
        out_valid <= dec_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw_ready && in_valid) begin
      raw <= in_data;
    end
    if (dec_ready && raw_valid) begin
      dec <= dec_next;
    end
    if (out_ready && dec_valid) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/rtcu_checker.sv -----
// ----------------------------------------------------------------------------
// RTC to Unix seconds: port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtc_fields_to_unix_seconds_defines.svh"

module rtcu_checker
  import rtcu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire rtcu_out_t out_data
);

  // A stalled result must stay put until the transaction completes.
  `RTCU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A bad month always reports a zero time.
  `RTCU_ASSERT_SAME(a_invalid_zero, out_valid && out_data.date_invalid, out_data.unix_seconds == 32'd0, "invalid date with nonzero seconds")

  // With no result waiting, the pipeline has room and must take input.
  `RTCU_ASSERT_SAME(a_no_false_stall, !out_valid, !in_stall, "input stalled while output empty")

endmodule

bind rtc_fields_to_unix_seconds rtcu_checker u_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the RTC fields to Unix seconds converter
// Sends clock-chip readings in BCD and binary form, in 24- and 12-hour mode,
// and compares every result with a typed-in value or a predictor kept inside
// the bench. A short table of directed readings runs first. Random readings
// follow, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rtcu_pkg::*;

  localparam int LongHold     = 60;
  localparam int IdleLimit    = 2000;
  localparam int PhaseCount   = 5;
  localparam int PhaseItems   = 190;
  localparam int DirectedRows = 25;

  localparam int unsigned MonthStart [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  localparam logic PhaseBinary [PhaseCount] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam logic PhaseHour24 [PhaseCount] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  typedef struct packed {
    logic        bin;
    logic        h24;
    rtcu_in_t    rd;
    logic        fixed;
    logic [31:0] secs;
    logic        inv;
  } directed_row_t;

  localparam directed_row_t DirectedReadings [DirectedRows] = '{
    // BCD, 24-hour
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946684800, 1'b0},
    '{1'b0, 1'b1, '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}, 1'b1, 32'd4102444799, 1'b0},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00}, 1'b1, 32'd951782400, 1'b0},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00}, 1'b1, 32'd951868800, 1'b0},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h1A, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h09, 8'hFF}, 1'b0, 32'd0, 1'b0},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01}, 1'b0, 32'd0, 1'b0},
    '{1'b0, 1'b1, '{8'h00, 8'h00, 8'h92, 8'h01, 8'h0A, 8'h96}, 1'b0, 32'd0, 1'b0},
    '{1'b0, 1'b1, '{8'h05, 8'h30, 8'h12, 8'h15, 8'h03, 8'h96}, 1'b0, 32'd0, 1'b0},
    // BCD, 12-hour
    '{1'b0, 1'b0, '{8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946684800, 1'b0},
    '{1'b0, 1'b0, '{8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946728000, 1'b0},
    '{1'b0, 1'b0, '{8'h00, 8'h00, 8'h81, 8'h01, 8'h01, 8'h00}, 1'b0, 32'd0, 1'b0},
    '{1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b0, 32'd0, 1'b0},
    // Binary, 24-hour
    '{1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946684800, 1'b0},
    '{1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0C, 8'hFF}, 1'b0, 32'd0, 1'b0},
    '{1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h0D, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00}, 1'b1, 32'd0, 1'b1},
    '{1'b1, 1'b1, '{8'h00, 8'h00, 8'h80, 8'h01, 8'h01, 8'h00}, 1'b0, 32'd0, 1'b0},
    // Binary, 12-hour
    '{1'b1, 1'b0, '{8'h00, 8'h00, 8'h0C, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946684800, 1'b0},
    '{1'b1, 1'b0, '{8'h00, 8'h00, 8'h8C, 8'h01, 8'h01, 8'h00}, 1'b1, 32'd946728000, 1'b0},
    '{1'b1, 1'b0, '{8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00}, 1'b0, 32'd0, 1'b0},
    '{1'b1, 1'b0, '{8'h00, 8'h00, 8'h7F, 8'h1F, 8'h02, 8'h00}, 1'b0, 32'd0, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  rtcu_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  rtcu_out_t out_data;
  logic      wr_en;
  logic      wr_index;
  logic      wr_data;

  // Bench copy of the two mode registers, used by the predictor.
  logic cfg_binary;
  logic cfg_h24;

  // Sideband that travels with the driven reading: a typed-in expectation.
  logic      row_fixed;
  rtcu_out_t row_fixed_value;

  rtcu_out_t awaited_times [$];

  int  mismatch_count = 0;
  int  readings_in = 0;
  int  results_out = 0;
  int  input_held_cycles = 0;
  int  mode_changes = 0;
  int  idle_cycles = 0;
  int  tx_run = 0;
  int  rx_run = 0;
  logic long_hold_req = 1'b0;

  rtc_fields_to_unix_seconds uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
  endfunction

  function automatic logic [7:0] encode_field(input int unsigned v, input logic bin);
    return bin ? 8'(v) : {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rtcu_out_t convert_rtc_reading(input rtcu_in_t rd, input logic bin,
                                                    input logic h24);
    logic [7:0]  sec_v, minute_v, day_v, mon_v, yr_v, hr_v;
    logic [63:0] year_abs, rel, day_of_year, total;
    rtcu_out_t   res;
    if (bin) begin
      sec_v    = rd.raw_second;
      minute_v = rd.raw_minute;
      day_v    = rd.raw_day;
      mon_v    = rd.raw_month;
      yr_v     = rd.raw_year;
      hr_v     = {1'b0, rd.raw_hour[6:0]};
    end else begin
      sec_v    = from_bcd(rd.raw_second);
      minute_v = from_bcd(rd.raw_minute);
      day_v    = from_bcd(rd.raw_day);
      mon_v    = from_bcd(rd.raw_month);
      yr_v     = from_bcd(rd.raw_year);
      // Only bits 6..4 form the tens digit; bit 7 is the PM flag.
      hr_v     = {5'd0, rd.raw_hour[6:4]} * 8'd10 + {4'd0, rd.raw_hour[3:0]};
    end
    if (!h24) begin
      if (hr_v == 8'd12) hr_v = 8'd0;
      if (rd.raw_hour[7]) hr_v = hr_v + 8'd12;
    end else if (bin) begin
      // Binary 24-hour mode keeps the whole byte, PM bit included.
      hr_v = rd.raw_hour;
    end
    res = '0;
    if (mon_v < 8'd1 || mon_v > 8'd12) begin
      res.date_invalid = 1'b1;
      return res;
    end
    year_abs    = 64'(BaseYear) + 64'(yr_v);
    rel         = year_abs - 64'(EpochYear);
    // A day of zero wraps below the month start; the sum is modulo 2^32 anyway.
    day_of_year = 64'(MonthStart[mon_v - 8'd1]) + 64'(day_v) - 64'd1;
    if (year_abs[1:0] == 2'd0 && mon_v >= 8'd3) day_of_year = day_of_year + 64'd1;
    total = rel * 64'(SecsPerYear) + ((rel + 64'd1) / 64'd4) * 64'(SecsPerDay)
          + day_of_year * 64'(SecsPerDay) + 64'(hr_v) * 64'(SecsPerHour)
          + 64'(minute_v) * 64'(SecsPerMinute) + 64'(sec_v);
    res.unix_seconds = total[31:0];
    return res;
  endfunction

  // Mostly uniform gaps, with occasional stretches of back-to-back transactions.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic send_reading(input rtcu_in_t rd, input logic fixed, input rtcu_out_t fixed_val);
    int gap;
    gap = draw_wait(tx_run);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_data         <= rd;
    row_fixed       <= fixed;
    row_fixed_value <= fixed_val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_times.size() != 0) @(negedge clk);
  endtask

  // Both registers are written back to back while the block is empty.
  task automatic apply_mode(input logic bin, input logic h24);
    wait_drained();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_BINARY_MODE;
    wr_data  <= bin;
    @(negedge clk);
    wr_index <= REG_HOUR_24_MODE;
    wr_data  <= h24;
    @(negedge clk);
    wr_en <= 1'b0;
    cfg_binary = bin;
    cfg_h24    = h24;
    mode_changes++;
  endtask

  // Monitor: checks results, queues an expectation for each accepted reading, and runs the watchdog.
  always @(posedge clk) begin
    rtcu_out_t expected_v;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (awaited_times.size() == 0) begin
          report_mismatch($sformatf("result %0d with no reading waiting", out_data.unix_seconds));
        end else begin
          expected_v = awaited_times.pop_front();
          if (out_data.unix_seconds !== expected_v.unix_seconds)
            report_mismatch($sformatf("unix_seconds got %0d expected %0d",
                                      out_data.unix_seconds, expected_v.unix_seconds));
          if (out_data.date_invalid !== expected_v.date_invalid)
            report_mismatch($sformatf("date_invalid got %0b expected %0b",
                                      out_data.date_invalid, expected_v.date_invalid));
        end
      end
      if (in_valid && in_stall) input_held_cycles++;
      if (in_valid && !in_stall) begin
        readings_in++;
        awaited_times.push_back(row_fixed ? row_fixed_value
                                          : convert_rtc_reading(in_data, cfg_binary, cfg_h24));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", IdleLimit);
        $display("FAIL rtc_fields_to_unix_seconds");
        $finish;
      end
    end
  end

  // Result side: random stall lengths, plus one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LongHold;
      end else begin
        n = draw_wait(rx_run);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rtcu_in_t    rd;
    rtcu_out_t   fixed_out;
    int unsigned hr;
    int unsigned yr;
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    wr_en           = 1'b0;
    wr_index        = REG_BINARY_MODE;
    wr_data         = 1'b0;
    row_fixed       = 1'b0;
    row_fixed_value = '0;
    cfg_binary      = 1'b0;
    cfg_h24         = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirectedRows; i++) begin
      if (DirectedReadings[i].bin != cfg_binary || DirectedReadings[i].h24 != cfg_h24)
        apply_mode(DirectedReadings[i].bin, DirectedReadings[i].h24);
      fixed_out.unix_seconds = DirectedReadings[i].secs;
      fixed_out.date_invalid = DirectedReadings[i].inv;
      send_reading(DirectedReadings[i].rd, DirectedReadings[i].fixed, fixed_out);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      apply_mode(PhaseBinary[p], PhaseHour24[p]);
      if (p == 1) begin
        // Hold the result side off while readings keep coming, so the pipe fills.
        long_hold_req = 1'b1;
        tx_run = 40;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 199) == 0) wait_drained();
        if ($urandom_range(0, 4) == 0) begin
          rd.raw_second = 8'($urandom);
          rd.raw_minute = 8'($urandom);
          rd.raw_hour   = 8'($urandom);
          rd.raw_day    = 8'($urandom);
          rd.raw_month  = 8'($urandom);
          rd.raw_year   = 8'($urandom);
        end else begin
          hr = cfg_h24 ? $urandom_range(0, 23) : $urandom_range(1, 12);
          yr = (cfg_binary && $urandom_range(0, 7) == 0) ? $urandom_range(100, 255)
                                                         : $urandom_range(0, 99);
          rd.raw_second = encode_field($urandom_range(0, 59), cfg_binary);
          rd.raw_minute = encode_field($urandom_range(0, 59), cfg_binary);
          rd.raw_hour   = encode_field(hr, cfg_binary);
          if (!cfg_h24) rd.raw_hour[7] = 1'($urandom_range(0, 1));
          rd.raw_day    = encode_field($urandom_range(1, 31), cfg_binary);
          rd.raw_month  = encode_field($urandom_range(1, 12), cfg_binary);
          rd.raw_year   = encode_field(yr, cfg_binary);
        end
        send_reading(rd, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);

    $display("Run covered %0d readings and %0d results over %0d mode settings.",
             readings_in, results_out, mode_changes);
    $display("Input was held off for %0d cycles; %0d mismatches were found.",
             input_held_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS rtc_fields_to_unix_seconds");
    end else begin
      $display("FAIL rtc_fields_to_unix_seconds");
    end
    $finish;
  end

endmodule
